@@ src/vlcp_pkg.sv @@
// shared types and constants for the variable length code packer
// no dependencies; compiled first
package vlcp_pkg;

  localparam int unsigned SymW     = 8;
  localparam int unsigned CodeInW  = 32;
  localparam int unsigned LenW     = 6;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PendW    = 7;
  localparam int unsigned PendCntW = 3;
  localparam int unsigned TableDepth = 256;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  // access request from the top level into the code table
  typedef struct packed {
    logic            wr_en;
    logic            rd_en;
    logic [SymW-1:0] addr;
    logic [LenW-1:0] len;
  } tbl_req_t;

endpackage

@@ src/vlcp_in_if.sv @@
// input channel: load, encode and flush words
// depends on vlcp_pkg
interface vlcp_in_if;
  import vlcp_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [SymW-1:0]     symbol;
  logic [CodeInW-1:0]  code_bits;
  logic [LenW-1:0]     code_length;

  modport source (output valid, op, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, op, symbol, code_bits, code_length, output ready);
endinterface

@@ src/vlcp_out_if.sv @@
// output channel: packed bytes and missing code errors
// depends on vlcp_pkg
interface vlcp_out_if;
  import vlcp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             missing_code;
  logic             last;

  modport source (output valid, out_byte, missing_code, last, input ready);
  modport sink   (input valid, out_byte, missing_code, last, output ready);
endinterface

@@ src/vlcp_table.sv @@
// per-symbol code table: code and length memories plus entry valid flags
// depends on vlcp_pkg
module vlcp_table #(
  parameter int unsigned CodeW = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  vlcp_pkg::tbl_req_t        req_i,
  input  logic [CodeW-1:0]          wr_code_i,
  output logic [CodeW-1:0]          rd_code_o,
  output logic [vlcp_pkg::LenW-1:0] rd_len_o,
  output logic                      rd_hit_o
);
  import vlcp_pkg::*;

  logic [CodeW-1:0] code_mem [TableDepth];
  logic [LenW-1:0]  len_mem  [TableDepth];
  logic [TableDepth-1:0] entry_valid_q;

  logic [CodeW-1:0] rd_code_q;
  logic [LenW-1:0]  rd_len_q;
  logic             rd_hit_q;

  // read happens before the write of the same edge; only one request per edge
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      code_mem[req_i.addr] <= wr_code_i;
      len_mem[req_i.addr]  <= req_i.len;
    end
    if (req_i.rd_en) begin
      rd_code_q <= code_mem[req_i.addr];
      rd_len_q  <= len_mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      rd_hit_q      <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        entry_valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_hit_q <= entry_valid_q[req_i.addr];
      end
    end
  end

  assign rd_code_o = rd_code_q;
  assign rd_len_o  = rd_len_q;
  assign rd_hit_o  = rd_hit_q;

endmodule

@@ src/variable_length_code_packer.sv @@
// top level of the prefix code packer: table lookup, bit accumulator, byte emitter
// depends on vlcp_pkg, vlcp_in_if, vlcp_out_if, vlcp_table
//
//   port    | dir | words carried
//   --------+-----+-----------------------------------------------
//   in_i    | in  | op, symbol, code_bits, code_length
//   out_o   | out | out_byte, missing_code, last
//
// a word is accepted each cycle while the byte buffer drains in time; the table
// read is registered, then the accumulator step lands in the byte buffer
// an encode giving more than one byte holds the byte buffer until it drains, so
// longer codes stall the input; all other words give at most one byte
// reset empties the pipeline and accumulator and marks every table entry invalid
// a stalled output holds its byte; the input stalls only once both stages are full
module variable_length_code_packer #(
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  vlcp_in_if.sink   in_i,
  vlcp_out_if.source out_o
);
  import vlcp_pkg::*;

  localparam int unsigned CodeW  = (MAX_CODE_LEN < CodeInW) ? MAX_CODE_LEN : CodeInW;
  localparam int unsigned AccW   = MAX_CODE_LEN + PendW;
  localparam int unsigned TotW   = $clog2(AccW + 1);
  localparam int unsigned MaxRes = AccW / ByteW;
  localparam int unsigned ResW   = $clog2(MaxRes + 1);

  // input side and table write
  tbl_req_t         tbl_req;
  logic             in_fire;
  logic [LenW-1:0]  ld_len;
  logic [CodeInW-1:0] ld_mask;
  logic [CodeW-1:0] ld_code;
  logic [CodeW-1:0] rd_code;
  logic [LenW-1:0]  rd_len;
  logic             rd_hit;

  // lookup stage
  logic s1_valid_q, s1_valid_d;
  op_e  s1_op_q;
  logic s1_fire;

  // accumulator
  logic [PendW-1:0]    pend_bits_q, pend_bits_d;
  logic [PendCntW-1:0] pend_cnt_q, pend_cnt_d;

  // byte buffer
  logic [AccW-1:0] obuf_q, obuf_d;
  logic [ResW-1:0] ocnt_q, ocnt_d;
  logic            miss_q, miss_d;
  logic            out_fire;

  // accumulator step
  logic [AccW-1:0] acc;
  logic [TotW-1:0] total;
  logic [TotW-1:0] align_sh;
  logic [PendW-1:0] keep_mask;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  assign ld_len  = (in_i.code_length > LenW'(MAX_CODE_LEN)) ? LenW'(MAX_CODE_LEN)
                                                            : in_i.code_length;
  assign ld_mask = ~({CodeInW{1'b1}} << ld_len);
  assign ld_code = CodeW'(in_i.code_bits & ld_mask);

  always_comb begin
    tbl_req.wr_en = in_fire && (in_i.op == OP_LOAD);
    tbl_req.rd_en = in_fire;
    tbl_req.addr  = in_i.symbol;
    tbl_req.len   = ld_len;
  end

  vlcp_table #(
    .CodeW (CodeW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tbl_req),
    .wr_code_i (ld_code),
    .rd_code_o (rd_code),
    .rd_len_o  (rd_len),
    .rd_hit_o  (rd_hit)
  );

  // lookup stage moves on when the byte buffer is empty or giving its last byte
  assign s1_fire    = s1_valid_q && ((ocnt_q == '0) || ((ocnt_q == ResW'(1)) && out_o.ready));
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign s1_valid_d = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);

  always_comb begin
    if (s1_op_q == OP_FLUSH) begin
      acc   = AccW'(pend_bits_q);
      total = TotW'(pend_cnt_q);
    end else begin
      acc   = (AccW'(pend_bits_q) << rd_len) | AccW'(rd_code);
      total = TotW'(pend_cnt_q) + TotW'(rd_len);
    end
    align_sh  = TotW'(AccW) - total;
    keep_mask = ~({PendW{1'b1}} << total[2:0]);
  end

  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    obuf_d      = obuf_q;
    ocnt_d      = ocnt_q;
    miss_d      = miss_q;
    if (out_fire) begin
      obuf_d = obuf_q << ByteW;
      ocnt_d = ocnt_q - ResW'(1);
    end
    if (s1_fire) begin
      unique case (s1_op_q)
        OP_ENCODE: begin
          if (!rd_hit) begin
            obuf_d = '0;
            ocnt_d = ResW'(1);
            miss_d = 1'b1;
          end else begin
            obuf_d      = acc << align_sh;
            ocnt_d      = ResW'(total >> 3);
            miss_d      = 1'b0;
            pend_bits_d = acc[PendW-1:0] & keep_mask;
            pend_cnt_d  = total[2:0];
          end
        end
        OP_FLUSH: begin
          // partial byte leaves zero padded at the bottom
          obuf_d      = acc << align_sh;
          ocnt_d      = (pend_cnt_q != '0) ? ResW'(1) : '0;
          miss_d      = 1'b0;
          pend_bits_d = '0;
          pend_cnt_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_op_q     <= OP_LOAD;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      ocnt_q      <= '0;
      miss_q      <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      if (in_fire) begin
        s1_op_q <= op_e'(in_i.op);
      end
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      ocnt_q      <= ocnt_d;
      miss_q      <= miss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
  end

  assign out_o.valid        = (ocnt_q != '0);
  assign out_o.out_byte     = obuf_q[AccW-1 -: ByteW];
  assign out_o.missing_code = miss_q;
  assign out_o.last         = (ocnt_q == ResW'(1));

`ifndef SYNTHESIS
  a_miss_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.missing_code) |-> (out_o.last && (out_o.out_byte == '0)))
    else $error("missing code result not a single zero byte");

  a_flush_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_op_q == OP_FLUSH)) |=> (pend_cnt_q == '0) && (pend_bits_q == '0))
    else $error("flush left pending bits");

  a_pend_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pend_bits_q >> pend_cnt_q) == '0))
    else $error("stray bits above pending count");

  a_stall_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (ocnt_q > ResW'(1))) |-> !in_i.ready)
    else $error("input taken while byte buffer busy");
`endif

endmodule
